@@ src/upc_pkg.sv @@
// Shared types, constants and helpers for the ultrasonic presence counter.
`timescale 1ns / 1ps

package upc_pkg;

    // Window length default and internal distance width (covers max + 10)
    localparam int WINDOW_LEN_DEF = 5;
    localparam int DIST_W         = 9;
    localparam int CFG_ADDR_W     = 5;

    // Register indexes on the config port (byte address = 4 * index)
    localparam logic [2:0] CFG_MIN_DIST   = 3'd0;
    localparam logic [2:0] CFG_MAX_DIST   = 3'd1;
    localparam logic [2:0] CFG_ENTER_THR  = 3'd2;
    localparam logic [2:0] CFG_EXIT_MARG  = 3'd3;
    localparam logic [2:0] CFG_MOVE_THR   = 3'd4;
    localparam logic [2:0] CFG_SPIKE_LIM  = 3'd5;
    localparam logic [2:0] CFG_CONFIRM_MS = 3'd6;
    localparam logic [2:0] CFG_ALARM_MS   = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_MIN_DIST   = 8'd5;
    localparam logic [7:0]  RST_MAX_DIST   = 8'd200;
    localparam logic [7:0]  RST_ENTER_THR  = 8'd50;
    localparam logic [5:0]  RST_EXIT_MARG  = 6'd6;
    localparam logic [7:0]  RST_MOVE_THR   = 8'd5;
    localparam logic [7:0]  RST_SPIKE_LIM  = 8'd75;
    localparam logic [15:0] RST_CONFIRM_MS = 16'd250;
    localparam logic [15:0] RST_ALARM_MS   = 16'd2000;

    // Distance substitutes and blink period
    localparam logic [DIST_W-1:0] TIMEOUT_EXTRA = 9'd10;
    localparam logic [DIST_W-1:0] RANGE_EXTRA   = 9'd5;
    localparam logic [DIST_W-1:0] DIST_CLIP     = 9'd255;
    localparam logic [31:0]       BLINK_MS      = 32'd500;

    // floor(us * 10 / 582) as a reciprocal multiply: exact for products below 2^18
    localparam int          ECHO_SCALED_W  = 18;
    localparam int          ECHO_PROD_W    = 36;
    localparam int          ECHO_DIV_SHIFT = 27;
    localparam logic [4:0]  ECHO_SCALE     = 5'd10;
    localparam logic [17:0] ECHO_DIV_MUL   = 18'd230615;

    // Input request
    typedef struct packed {
        logic        action;
        logic [13:0] echo_us;
        logic [31:0] now_ms;
    } t_in_req;

    // Result item
    typedef struct packed {
        logic [7:0]  distance_cm;
        logic        present;
        logic        confirmed;
        logic        still_alarm;
        logic        leds_on;
        logic [31:0] people_count;
        logic        counted_pulse;
        logic        confirmed_pulse;
    } t_out_res;

    // Configuration registers
    typedef struct packed {
        logic [7:0]  min_distance;
        logic [7:0]  max_distance;
        logic [7:0]  enter_threshold;
        logic [5:0]  exit_margin;
        logic [7:0]  movement_threshold;
        logic [7:0]  spike_limit;
        logic [15:0] confirm_time_ms;
        logic [15:0] alarm_time_ms;
    } t_cfg;

    // Captured sample after echo conversion
    typedef struct packed {
        logic              action;
        logic              timeout;
        logic [DIST_W-1:0] raw;
        logic [31:0]       now_ms;
    } t_smp;

    // Tracker status seen by the filter
    typedef struct packed {
        logic       present;
        logic [7:0] last_stable;
    } t_trk;

    function automatic logic [DIST_W-1:0] abs_diff(input logic [DIST_W-1:0] a,
                                                   input logic [DIST_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ src/ultrasonic_presence_counter_core.sv @@
// Top level of the ultrasonic presence counter: request stage, result stage, config port.
//
//   Channel   Direction  Handshake                   Payload
//   in        sink       i_in_valid / o_in_stall     i_in  (upc_pkg::t_in_req)
//   out       source     o_out_valid / i_out_stall   o_out (upc_pkg::t_out_res)
//   config    sink       psel / penable / pready     paddr, pwdata, prdata
//
// One request per clock sustained while the output is not stalled; echo conversion feeds the
// request register, then filter and tracker feed the result register.
// The echo multiplier sits before the request register, the window average multiplier
// and presence logic between the request and result registers.
// Synchronous active-low reset; no clearing pass, the block takes requests right after.
// A stalled result holds in its register while one more request waits in the request stage.
`timescale 1ns / 1ps

module ultrasonic_presence_counter_core #(
    parameter int WINDOW_LEN = upc_pkg::WINDOW_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  upc_pkg::t_in_req                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output upc_pkg::t_out_res                o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [upc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    upc_pkg::t_cfg              cfg;
    upc_pkg::t_trk              trk;
    upc_pkg::t_smp              r_smp;
    upc_pkg::t_smp              n_smp;
    upc_pkg::t_out_res          r_out;
    upc_pkg::t_out_res          res;
    logic                       r_smp_vld;
    logic                       r_out_vld;
    logic [upc_pkg::DIST_W-1:0] filt_dist;
    logic                       conv_timeout;
    logic [upc_pkg::DIST_W-1:0] conv_raw;
    logic                       out_take, out_free, advance, in_acc;

    upc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    upc_echo_conv u_conv (
        .i_echo_us (i_in.echo_us),
        .o_timeout (conv_timeout),
        .o_raw     (conv_raw)
    );

    // Handshake between the two stages
    assign out_take    = r_out_vld && !i_out_stall;
    assign out_free    = !r_out_vld || out_take;
    assign advance     = r_smp_vld && out_free;
    assign o_in_stall  = r_smp_vld && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign n_smp.action  = i_in.action;
    assign n_smp.timeout = conv_timeout;
    assign n_smp.raw     = conv_raw;
    assign n_smp.now_ms  = i_in.now_ms;

    upc_filter #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_smp   (r_smp),
        .i_cfg   (cfg),
        .i_trk   (trk),
        .o_dist  (filt_dist)
    );

    upc_tracker u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_smp   (r_smp),
        .i_dist  (filt_dist),
        .i_cfg   (cfg),
        .o_trk   (trk),
        .o_res   (res)
    );

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_smp_vld <= 1'b1;
            end else if (advance) begin
                r_smp_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Capture the request and the result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp <= n_smp;
        end
        if (advance) begin
            r_out <= res;
        end
    end

endmodule

@@ src/upc_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module upc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [upc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output upc_pkg::t_cfg                    o_cfg
);

    upc_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_distance       <= upc_pkg::RST_MIN_DIST;
            r_cfg.max_distance       <= upc_pkg::RST_MAX_DIST;
            r_cfg.enter_threshold    <= upc_pkg::RST_ENTER_THR;
            r_cfg.exit_margin        <= upc_pkg::RST_EXIT_MARG;
            r_cfg.movement_threshold <= upc_pkg::RST_MOVE_THR;
            r_cfg.spike_limit        <= upc_pkg::RST_SPIKE_LIM;
            r_cfg.confirm_time_ms    <= upc_pkg::RST_CONFIRM_MS;
            r_cfg.alarm_time_ms      <= upc_pkg::RST_ALARM_MS;
        end else if (wr_en) begin
            case (reg_idx)
                upc_pkg::CFG_MIN_DIST:   r_cfg.min_distance       <= pwdata[7:0];
                upc_pkg::CFG_MAX_DIST:   r_cfg.max_distance       <= pwdata[7:0];
                upc_pkg::CFG_ENTER_THR:  r_cfg.enter_threshold    <= pwdata[7:0];
                upc_pkg::CFG_EXIT_MARG:  r_cfg.exit_margin        <= pwdata[5:0];
                upc_pkg::CFG_MOVE_THR:   r_cfg.movement_threshold <= pwdata[7:0];
                upc_pkg::CFG_SPIKE_LIM:  r_cfg.spike_limit        <= pwdata[7:0];
                upc_pkg::CFG_CONFIRM_MS: r_cfg.confirm_time_ms    <= pwdata[15:0];
                upc_pkg::CFG_ALARM_MS:   r_cfg.alarm_time_ms      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            upc_pkg::CFG_MIN_DIST:   prdata = {24'd0, r_cfg.min_distance};
            upc_pkg::CFG_MAX_DIST:   prdata = {24'd0, r_cfg.max_distance};
            upc_pkg::CFG_ENTER_THR:  prdata = {24'd0, r_cfg.enter_threshold};
            upc_pkg::CFG_EXIT_MARG:  prdata = {26'd0, r_cfg.exit_margin};
            upc_pkg::CFG_MOVE_THR:   prdata = {24'd0, r_cfg.movement_threshold};
            upc_pkg::CFG_SPIKE_LIM:  prdata = {24'd0, r_cfg.spike_limit};
            upc_pkg::CFG_CONFIRM_MS: prdata = {16'd0, r_cfg.confirm_time_ms};
            upc_pkg::CFG_ALARM_MS:   prdata = {16'd0, r_cfg.alarm_time_ms};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

@@ src/upc_echo_conv.sv @@
// Echo width to whole centimetres by reciprocal multiplication.
`timescale 1ns / 1ps

module upc_echo_conv (
    input  logic [13:0]                  i_echo_us,
    output logic                         o_timeout,
    output logic [upc_pkg::DIST_W-1:0]   o_raw
);

    logic [upc_pkg::ECHO_SCALED_W-1:0] scaled;
    logic [upc_pkg::ECHO_PROD_W-1:0]   prod;

    // Scale by ten, then divide by 582 through the reciprocal
    assign scaled    = upc_pkg::ECHO_SCALED_W'(i_echo_us) *
                       upc_pkg::ECHO_SCALED_W'(upc_pkg::ECHO_SCALE);
    assign prod      = upc_pkg::ECHO_PROD_W'(scaled) *
                       upc_pkg::ECHO_PROD_W'(upc_pkg::ECHO_DIV_MUL);
    assign o_raw     = prod[upc_pkg::ECHO_DIV_SHIFT +: upc_pkg::DIST_W];
    assign o_timeout = (i_echo_us == 14'd0);

endmodule

@@ src/upc_filter.sv @@
// Range check, spike rejection and moving-average window.
`timescale 1ns / 1ps

module upc_filter #(
    parameter int WINDOW_LEN = upc_pkg::WINDOW_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  upc_pkg::t_smp                i_smp,
    input  upc_pkg::t_cfg                i_cfg,
    input  upc_pkg::t_trk                i_trk,
    output logic [upc_pkg::DIST_W-1:0]   o_dist
);

    localparam int POS_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W     = $clog2(255 * WINDOW_LEN + 1);
    localparam int AVG_SHIFT = SUM_W + 5;
    localparam int MUL_W     = AVG_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] AVG_MUL =
        MUL_W'(((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0] SUM_RST  =
        SUM_W'(int'(upc_pkg::RST_MAX_DIST) * WINDOW_LEN);

    logic [7:0]                  r_win [WINDOW_LEN];
    logic [SUM_W-1:0]            r_sum;
    logic [POS_W-1:0]            r_pos;
    logic [SUM_W-1:0]            n_sum;
    logic [PROD_W-1:0]           avg_prod;
    logic [upc_pkg::DIST_W-1:0]  max9;
    logic                        out_of_range;
    logic                        spike;
    logic                        take;

    assign max9         = {1'b0, i_cfg.max_distance};
    assign out_of_range = (i_smp.raw < {1'b0, i_cfg.min_distance}) || (i_smp.raw > max9);
    assign spike        = i_trk.present &&
                          (upc_pkg::abs_diff(i_smp.raw, {1'b0, i_trk.last_stable}) >
                           {1'b0, i_cfg.spike_limit});
    assign take         = !i_smp.action && !i_smp.timeout && !out_of_range && !spike;

    // Replace the oldest entry in the running sum
    assign n_sum    = r_sum - SUM_W'(r_win[r_pos]) + SUM_W'(i_smp.raw[7:0]);
    assign avg_prod = PROD_W'(n_sum) * PROD_W'(AVG_MUL);

    // Pick the distance for this sample
    always_comb begin
        if (i_smp.timeout) begin
            o_dist = max9 + upc_pkg::TIMEOUT_EXTRA;
        end else if (out_of_range) begin
            o_dist = max9 + upc_pkg::RANGE_EXTRA;
        end else if (spike) begin
            o_dist = {1'b0, i_trk.last_stable};
        end else begin
            o_dist = {1'b0, avg_prod[AVG_SHIFT +: 8]};
        end
    end

    // Advance the window on an accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= upc_pkg::RST_MAX_DIST;
            end
            r_sum <= SUM_RST;
            r_pos <= '0;
        end else if (i_step && take) begin
            r_win[r_pos] <= i_smp.raw[7:0];
            r_sum        <= n_sum;
            r_pos        <= (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
        end
    end

endmodule

@@ src/upc_tracker.sv @@
// Presence, confirmation, stillness alarm, LED blink and people count.
`timescale 1ns / 1ps

module upc_tracker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  upc_pkg::t_smp                i_smp,
    input  logic [upc_pkg::DIST_W-1:0]   i_dist,
    input  upc_pkg::t_cfg                i_cfg,
    output upc_pkg::t_trk                o_trk,
    output upc_pkg::t_out_res            o_res
);

    logic        r_present, r_confirmed, r_alarm, r_led;
    logic [7:0]  r_last;
    logic [31:0] r_entry, r_move, r_toggle, r_count;

    logic        n_present, n_confirmed, n_alarm, n_led;
    logic [7:0]  n_last;
    logic [31:0] n_entry, n_move, n_toggle, n_count;
    logic        cnt_pulse, conf_pulse;

    logic [upc_pkg::DIST_W-1:0] exit_lvl;
    logic                       moved;
    logic [31:0]                now;

    assign now      = i_smp.now_ms;
    assign exit_lvl = {1'b0, i_cfg.enter_threshold} + upc_pkg::DIST_W'(i_cfg.exit_margin);
    assign moved    = upc_pkg::abs_diff(i_dist, {1'b0, r_last}) >
                      {1'b0, i_cfg.movement_threshold};

    assign o_trk.present     = r_present;
    assign o_trk.last_stable = r_last;

    // Next state for one request
    always_comb begin
        n_present   = r_present;
        n_confirmed = r_confirmed;
        n_alarm     = r_alarm;
        n_led       = r_led;
        n_last      = r_last;
        n_entry     = r_entry;
        n_move      = r_move;
        n_toggle    = r_toggle;
        n_count     = r_count;
        cnt_pulse   = 1'b0;
        conf_pulse  = 1'b0;
        if (i_smp.action) begin
            // Counter reset command
            n_count     = 32'd0;
            n_present   = 1'b0;
            n_confirmed = 1'b0;
            n_last      = i_cfg.max_distance;
            n_alarm     = 1'b0;
            n_led       = 1'b0;
        end else begin
            if (i_dist < {1'b0, i_cfg.enter_threshold}) begin
                if (!r_present) begin
                    n_present   = 1'b1;
                    n_confirmed = 1'b0;
                    n_entry     = now;
                    n_move      = now;
                end else begin
                    if (moved) begin
                        n_move = now;
                        if (r_alarm) begin
                            n_alarm = 1'b0;
                            n_led   = 1'b0;
                        end
                    end
                    if (!r_confirmed && ((now - r_entry) >= 32'(i_cfg.confirm_time_ms))) begin
                        n_confirmed = 1'b1;
                        conf_pulse  = 1'b1;
                    end
                    if (n_confirmed && !n_alarm &&
                        ((now - n_move) >= 32'(i_cfg.alarm_time_ms))) begin
                        n_alarm  = 1'b1;
                        n_toggle = now;
                    end
                end
                n_last = i_dist[7:0];
            end else if (i_dist >= exit_lvl) begin
                // Confirmed exit bumps the count
                if (r_present) begin
                    if (r_confirmed) begin
                        n_count   = r_count + 32'd1;
                        cnt_pulse = 1'b1;
                    end
                    n_present   = 1'b0;
                    n_confirmed = 1'b0;
                    n_last      = i_cfg.max_distance;
                    if (r_alarm) begin
                        n_alarm = 1'b0;
                        n_led   = 1'b0;
                    end
                end
            end
            // Blink while the alarm holds
            if (n_alarm && ((now - n_toggle) >= upc_pkg::BLINK_MS)) begin
                n_toggle = now;
                n_led    = !n_led;
            end
        end
    end

    // Result fields
    always_comb begin
        if (i_smp.action) begin
            o_res.distance_cm = 8'd0;
        end else if (i_dist > upc_pkg::DIST_CLIP) begin
            o_res.distance_cm = 8'd255;
        end else begin
            o_res.distance_cm = i_dist[7:0];
        end
        o_res.present         = n_present;
        o_res.confirmed       = n_confirmed;
        o_res.still_alarm     = n_alarm;
        o_res.leds_on         = n_led;
        o_res.people_count    = n_count;
        o_res.counted_pulse   = cnt_pulse;
        o_res.confirmed_pulse = conf_pulse;
    end

    // Hold state between requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_confirmed <= 1'b0;
            r_alarm     <= 1'b0;
            r_led       <= 1'b0;
            r_last      <= upc_pkg::RST_MAX_DIST;
            r_entry     <= 32'd0;
            r_move      <= 32'd0;
            r_toggle    <= 32'd0;
            r_count     <= 32'd0;
        end else if (i_step) begin
            r_present   <= n_present;
            r_confirmed <= n_confirmed;
            r_alarm     <= n_alarm;
            r_led       <= n_led;
            r_last      <= n_last;
            r_entry     <= n_entry;
            r_move      <= n_move;
            r_toggle    <= n_toggle;
            r_count     <= n_count;
        end
    end

endmodule
